FILE: rtl/pfp_pkg.sv
// Shared constants and types for the position frame parser.
`default_nettype none

package pfp_pkg;

  localparam int unsigned CoordW = 16;

  typedef logic [7:0]               byte_t;
  typedef logic [3:0]               frame_pos_t;
  typedef logic signed [CoordW-1:0] coord_t;

  // Frame layout: start, 3 x (sign, 3 digits), terminator
  localparam byte_t      START_BYTE  = 8'h5A;  // 'Z'
  localparam byte_t      END_BYTE    = 8'h0A;  // newline
  localparam byte_t      MINUS_BYTE  = 8'h2D;  // '-'
  localparam byte_t      ZERO_BYTE   = 8'h30;  // '0'
  localparam frame_pos_t FRAME_HUNT  = 4'd0;
  localparam frame_pos_t FRAME_FIRST = 4'd1;
  localparam frame_pos_t FRAME_LAST  = 4'd13;
  localparam coord_t     ERROR_VALUE = 16'sd999;

  // Group slot within a sign+digits group
  localparam logic [1:0] SLOT_SIGN = 2'd0;
  localparam logic [1:0] SLOT_HUND = 2'd1;
  localparam logic [1:0] SLOT_TENS = 2'd2;

  localparam logic [1:0] GRP_X = 2'd0;
  localparam logic [1:0] GRP_Y = 2'd1;

endpackage : pfp_pkg

`default_nettype wire

FILE: rtl/position_frame_parser.sv
// Top level: byte-stream parser for 14-byte position frames.
`default_nettype none

// Accepts one received byte per clock and hunts for frames of the form
// 'Z', then three groups of a sign byte and three digit bytes, then newline.
// A '-' sign negates its group; digits are not range checked, each group is
// (d0-'0')*100 + (d1-'0')*10 + (d2-'0'). A valid newline at frame byte 13
// yields one result (x, y, z, and coord_error when x is +999) in the cycle
// after that byte is taken. Any other byte 13 drops the frame and is
// rechecked as a start byte. Throughput is one byte per cycle: each byte
// updates the frame counter and at most one accumulator or sign flag, and
// the result register lets in_ready stay high unless a result is waiting
// with out_ready low.
module position_frame_parser
  import pfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic signed [15:0]      out_pos_z,
  output logic                    out_coord_error
);

  frame_pos_t frame_pos_r, frame_pos_nxt;
  coord_t     acc_x_r, acc_y_r, acc_z_r;
  coord_t     acc_x_nxt, acc_y_nxt, acc_z_nxt;
  logic       neg_x_r, neg_y_r, neg_z_r;
  logic       neg_x_nxt, neg_y_nxt, neg_z_nxt;
  logic       out_valid_r, out_valid_nxt;
  coord_t     pos_x_r, pos_y_r, pos_z_r;
  logic       coord_error_r;

  logic       accept;
  logic       emit;
  frame_pos_t pos_m1;
  logic [1:0] group;
  logic [1:0] slot;
  coord_t     digit;
  coord_t     acc_sel;
  coord_t     acc_upd;
  coord_t     x_val, y_val, z_val;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign pos_m1 = frame_pos_r - FRAME_FIRST;
  assign group  = pos_m1[3:2];
  assign slot   = pos_m1[1:0];
  assign digit  = coord_t'($signed({8'h00, in_rx_byte})) -
                  coord_t'($signed({8'h00, ZERO_BYTE}));

  always_comb begin
    case (group)
      GRP_X:   acc_sel = acc_x_r;
      GRP_Y:   acc_sel = acc_y_r;
      default: acc_sel = acc_z_r;
    endcase
  end

  always_comb begin
    case (slot)
      SLOT_HUND: acc_upd = coord_t'(digit * 16'sd100);
      SLOT_TENS: acc_upd = acc_sel + coord_t'(digit * 16'sd10);
      default:   acc_upd = acc_sel + digit;
    endcase
  end

  assign x_val = neg_x_r ? -acc_x_r : acc_x_r;
  assign y_val = neg_y_r ? -acc_y_r : acc_y_r;
  assign z_val = neg_z_r ? -acc_z_r : acc_z_r;

  always_comb begin
    frame_pos_nxt = frame_pos_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    acc_z_nxt     = acc_z_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    neg_z_nxt     = neg_z_r;
    emit          = 1'b0;
    if (accept) begin
      if (frame_pos_r == FRAME_HUNT || frame_pos_r > FRAME_LAST) begin
        frame_pos_nxt = (in_rx_byte == START_BYTE) ? FRAME_FIRST : FRAME_HUNT;
      end else if (frame_pos_r == FRAME_LAST) begin
        if (in_rx_byte == END_BYTE) begin
          frame_pos_nxt = FRAME_HUNT;
          emit          = 1'b1;
        end else begin
          // bad terminator: this byte may open the next frame
          frame_pos_nxt = (in_rx_byte == START_BYTE) ? FRAME_FIRST : FRAME_HUNT;
        end
      end else begin
        frame_pos_nxt = frame_pos_r + FRAME_FIRST;
        if (slot == SLOT_SIGN) begin
          case (group)
            GRP_X:   neg_x_nxt = (in_rx_byte == MINUS_BYTE);
            GRP_Y:   neg_y_nxt = (in_rx_byte == MINUS_BYTE);
            default: neg_z_nxt = (in_rx_byte == MINUS_BYTE);
          endcase
        end else begin
          case (group)
            GRP_X:   acc_x_nxt = acc_upd;
            GRP_Y:   acc_y_nxt = acc_upd;
            default: acc_z_nxt = acc_upd;
          endcase
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r <= FRAME_HUNT;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_z_r     <= '0;
      neg_x_r     <= 1'b0;
      neg_y_r     <= 1'b0;
      neg_z_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      frame_pos_r <= frame_pos_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      acc_z_r     <= acc_z_nxt;
      neg_x_r     <= neg_x_nxt;
      neg_y_r     <= neg_y_nxt;
      neg_z_r     <= neg_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pos_x_r       <= x_val;
      pos_y_r       <= y_val;
      pos_z_r       <= z_val;
      coord_error_r <= (x_val == ERROR_VALUE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_pos_z       = pos_z_r;
  assign out_coord_error = coord_error_r;

  // frame counter never leaves the frame range
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_pos_r <= FRAME_LAST)
    else $error("frame position out of range");

  // a new result only follows the last frame byte
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(frame_pos_r) == FRAME_LAST)
    else $error("result raised outside frame end");

  // good terminator gives a result and returns to hunting
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_pos_r == FRAME_LAST && in_rx_byte == END_BYTE)
      |=> (out_valid_r && frame_pos_r == FRAME_HUNT))
    else $error("completed frame lost");

  // error flag only with positive 999
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && coord_error_r) |-> pos_x_r == ERROR_VALUE)
    else $error("coord_error without x of 999");

endmodule : position_frame_parser

`default_nettype wire
